>>> rtl/dbcw_pkg.sv
package dbcw_pkg;

  localparam int WINDOW_FRAC_BITS_DEF = 16;
  localparam int TIME_BITS_DEF        = 32;

  localparam logic [15:0] MIN_RTT_PERIOD_RESET = 16'd10000;
  localparam logic [7:0]  MIN_WINDOW_RESET     = 8'd1;

  localparam int RTT_W  = 32;
  localparam int SRTT_W = 40;
  localparam int VEL_W  = 5;

  localparam logic [RTT_W-1:0] RTT_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [0:0] CFG_MIN_RTT_PERIOD = 1'b0;
  localparam logic [0:0] CFG_MIN_WINDOW     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRTT_MUL,
    ST_SRTT_ADD,
    ST_MIN,
    ST_CHECK,
    ST_PREP,
    ST_ITER,
    ST_APPLY,
    ST_DIR,
    ST_DONE
  } state_e;

endpackage

>>> rtl/delay_based_congestion_window_core.sv
// Timeout word: goes straight to DONE; next word accepted once the result is loaded.
// Acknowledgement word: SRTT_MUL, SRTT_ADD, MIN and CHECK, then DONE when no window round
// closes, else PREP, ITER, APPLY, DIR and DONE, where ITER runs N = max(6 + 2*F, 32) steps:
// iterations of the bit-serial divider (window step) and bit-serial rate-test multiplier.
// Words are handled one at a time; the output register lets a new word enter early.
// Asynchronous active-low reset restores all controller state and both registers.
module delay_based_congestion_window_core #(
  parameter int WINDOW_FRAC_BITS = dbcw_pkg::WINDOW_FRAC_BITS_DEF,
  parameter int TIME_BITS        = dbcw_pkg::TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] sent_time_ms_i,
  input  logic [31:0] ack_time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] window_datagrams_o,
  output logic        in_slow_start_o
);

  localparam int F     = WINDOW_FRAC_BITS;
  localparam int T     = TIME_BITS;
  localparam int W     = 16 + F;
  localparam int IT    = (6 + 2 * F > 32) ? 6 + 2 * F : 32;
  localparam int RW    = dbcw_pkg::RTT_W + 1 + F;
  localparam int PW    = RW + 2;
  localparam int CNT_W = $clog2(IT);
  localparam int EW    = (T > dbcw_pkg::RTT_W) ? T : dbcw_pkg::RTT_W;
  localparam int SW    = dbcw_pkg::SRTT_W;
  localparam int VW    = dbcw_pkg::VEL_W;

  dbcw_pkg::state_e state_q, state_d;

  logic [15:0]    period_q;
  logic [7:0]     min_win_q;

  logic [SW-1:0]  srtt_q;
  logic [31:0]    long_min_q;
  logic [T-1:0]   long_time_q;
  logic [31:0]    stand_q;
  logic [T-1:0]   stand_time_q;
  logic [W-1:0]   win_q;
  logic [15:0]    acks_q;
  logic           slow_q;
  logic [VW-1:0]  vel_q;
  logic [1:0]     same_q;
  logic           prev_up_q;
  logic [15:0]    prev_win_q;

  logic [31:0]    rtt_q;
  logic [T-1:0]   ack_q;
  logic [SW+2:0]  srtt7_q;
  logic [IT-1:0]  num_q;
  logic [IT-1:0]  quo_q;
  logic [W-1:0]   rem_q;
  logic [IT-1:0]  qd_q;
  logic [RW-1:0]  rhs_q;
  logic [RW-1:0]  prod_q;
  logic           over_q;
  logic [CNT_W-1:0] cnt_q;

  logic           out_valid_q;
  logic [15:0]    out_win_q;
  logic           out_slow_q;

  logic           accept;
  logic           load_out;
  logic           close_round;
  logic [T-1:0]   diff_t;
  logic [EW-1:0]  diff_e;
  logic [31:0]    rtt_sat;
  logic [SW+2:0]  srtt_sum;
  logic [T-1:0]   long_age;
  logic [T-1:0]   stand_age;
  logic           long_upd;
  logic           stand_upd;
  logic [7:0]     min_win_eff;
  logic [31:0]    qd;
  logic [W:0]     rem_sh;
  logic           quo_bit;
  logic [PW-1:0]  prod_try;
  logic           increase;
  logic           dir_up;

  assign in_ready_o         = (state_q == dbcw_pkg::ST_IDLE);
  assign accept             = in_valid_i && in_ready_o;
  assign out_valid_o        = out_valid_q;
  assign window_datagrams_o = out_win_q;
  assign in_slow_start_o    = out_slow_q;

  // RTT over a time base of T bits; a wrap beyond 32 bits saturates.
  assign diff_t  = T'(ack_time_ms_i) - T'(sent_time_ms_i);
  assign diff_e  = EW'(diff_t);
  assign rtt_sat = (diff_e > EW'(dbcw_pkg::RTT_MAX)) ? dbcw_pkg::RTT_MAX : diff_e[31:0];

  assign srtt_sum  = srtt7_q + {3'd0, rtt_q, 8'd0};
  assign long_age  = ack_q - long_time_q;
  assign stand_age = ack_q - stand_time_q;
  assign long_upd  = (EW'(long_age) > EW'(period_q)) || (rtt_q < long_min_q);
  assign stand_upd = (EW'(stand_age) > EW'(srtt_q[SW-1:9])) || (rtt_q < stand_q);

  assign close_round = ({acks_q, {F{1'b0}}} >= win_q);
  assign min_win_eff = (min_win_q == 8'd0) ? 8'd1 : min_win_q;
  assign qd          = (stand_q > long_min_q) ? (stand_q - long_min_q) : 32'd0;

  // One restoring division step and one multiply step per cycle.
  assign rem_sh   = {rem_q, num_q[IT-1]};
  assign quo_bit  = (rem_sh >= {1'b0, win_q});
  assign prod_try = {1'b0, prod_q, 1'b0} + (qd_q[IT-1] ? PW'(win_q) : PW'(0));

  assign increase = !over_q;
  assign dir_up   = (win_q > {prev_win_q, {F{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbcw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      dbcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = opcode_i ? dbcw_pkg::ST_DONE : dbcw_pkg::ST_SRTT_MUL;
        end
      end
      dbcw_pkg::ST_SRTT_MUL: state_d = dbcw_pkg::ST_SRTT_ADD;
      dbcw_pkg::ST_SRTT_ADD: state_d = dbcw_pkg::ST_MIN;
      dbcw_pkg::ST_MIN:      state_d = dbcw_pkg::ST_CHECK;
      dbcw_pkg::ST_CHECK: begin
        state_d = close_round ? dbcw_pkg::ST_PREP : dbcw_pkg::ST_DONE;
      end
      dbcw_pkg::ST_PREP:     state_d = dbcw_pkg::ST_ITER;
      dbcw_pkg::ST_ITER: begin
        if (cnt_q == CNT_W'(0)) begin
          state_d = dbcw_pkg::ST_APPLY;
        end
      end
      dbcw_pkg::ST_APPLY:    state_d = dbcw_pkg::ST_DIR;
      dbcw_pkg::ST_DIR:      state_d = dbcw_pkg::ST_DONE;
      dbcw_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = dbcw_pkg::ST_IDLE;
        end
      end
      default: state_d = dbcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= dbcw_pkg::MIN_RTT_PERIOD_RESET;
      min_win_q    <= dbcw_pkg::MIN_WINDOW_RESET;
      srtt_q       <= '0;
      long_min_q   <= '1;
      long_time_q  <= '0;
      stand_q      <= '1;
      stand_time_q <= '0;
      win_q        <= W'(1) << F;
      acks_q       <= '0;
      slow_q       <= 1'b1;
      vel_q        <= VW'(1);
      same_q       <= '0;
      prev_up_q    <= 1'b1;
      prev_win_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dbcw_pkg::CFG_MIN_RTT_PERIOD: period_q  <= cfg_data_i;
          dbcw_pkg::CFG_MIN_WINDOW:     min_win_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        dbcw_pkg::ST_IDLE: begin
          if (accept && opcode_i) begin
            win_q  <= '0;
            slow_q <= 1'b1;
          end
        end
        dbcw_pkg::ST_SRTT_ADD: begin
          if (srtt_q == '0) begin
            srtt_q <= {rtt_q, 8'd0};
          end else begin
            srtt_q <= srtt_sum[SW+2:3];
          end
        end
        dbcw_pkg::ST_MIN: begin
          if (long_upd) begin
            long_min_q  <= rtt_q;
            long_time_q <= ack_q;
          end
          if (stand_upd) begin
            stand_q      <= rtt_q;
            stand_time_q <= ack_q;
          end
          if (acks_q != 16'hFFFF) begin
            acks_q <= acks_q + 16'd1;
          end
        end
        dbcw_pkg::ST_CHECK: begin
          // A round that starts from a closed window reopens it first.
          if (close_round && (win_q == '0)) begin
            win_q <= {8'd0, min_win_eff, {F{1'b0}}};
          end
        end
        dbcw_pkg::ST_APPLY: begin
          acks_q <= '0;
          if (increase) begin
            if (slow_q) begin
              win_q <= win_q[W-1] ? '1 : {win_q[W-2:0], 1'b0};
            end else if (quo_q > IT'(~win_q)) begin
              win_q <= '1;
            end else begin
              win_q <= win_q + quo_q[W-1:0];
            end
          end else begin
            slow_q <= 1'b0;
            win_q  <= (quo_q >= IT'(win_q)) ? '0 : (win_q - quo_q[W-1:0]);
          end
        end
        dbcw_pkg::ST_DIR: begin
          if (dir_up == prev_up_q) begin
            if (same_q == 2'd2) begin
              vel_q  <= (vel_q > VW'(8)) ? VW'(2) : {vel_q[VW-2:0], 1'b0};
              same_q <= '0;
            end else begin
              same_q <= same_q + 2'd1;
            end
          end else begin
            vel_q <= VW'(1);
          end
          prev_win_q <= win_q[W-1:F];
          prev_up_q  <= dir_up;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rtt_q <= rtt_sat;
      ack_q <= T'(ack_time_ms_i);
    end
    if (load_out) begin
      out_win_q  <= win_q[W-1:F];
      out_slow_q <= slow_q;
    end
    unique case (state_q)
      dbcw_pkg::ST_SRTT_MUL: begin
        srtt7_q <= {srtt_q, 3'd0} - {3'd0, srtt_q};
      end
      dbcw_pkg::ST_PREP: begin
        qd_q   <= IT'(qd);
        rhs_q  <= {stand_q, 1'b0, {F{1'b0}}};
        prod_q <= '0;
        over_q <= 1'b0;
        num_q  <= IT'({vel_q, 1'b0}) << (2 * F);
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= CNT_W'(IT - 1);
      end
      dbcw_pkg::ST_ITER: begin
        num_q <= {num_q[IT-2:0], 1'b0};
        quo_q <= {quo_q[IT-2:0], quo_bit};
        rem_q <= quo_bit ? (rem_sh[W-1:0] - win_q) : rem_sh[W-1:0];
        // Once the partial product passes the bound it can only grow, so stop there.
        if (!over_q) begin
          if (prod_try > PW'(rhs_q)) begin
            over_q <= 1'b1;
          end else begin
            prod_q <= prod_try[RW-1:0];
          end
        end
        qd_q  <= {qd_q[IT-2:0], 1'b0};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> tb/tb_delay_based_congestion_window_core.sv
module tb_delay_based_congestion_window_core;

  localparam int FRAC = dbcw_pkg::WINDOW_FRAC_BITS_DEF;
  localparam logic [63:0] WIN_MAX = (64'd1 << (16 + FRAC)) - 64'd1;
  localparam logic [63:0] SRTT_MASK = (64'd1 << dbcw_pkg::SRTT_W) - 64'd1;
  localparam logic [63:0] ALL32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic OP_ACK = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int WORDS_PER_PHASE = 255;
  localparam int N_PROBES = 20;

  typedef struct packed {
    logic [15:0] window;
    logic        slow;
  } window_res_t;

  typedef struct packed {
    logic        op;
    logic [31:0] sent;
    logic [31:0] ack;
    logic        typed;
    logic [15:0] window;
    logic        slow;
  } probe_t;

  // Directed words; rows marked typed carry a result that is obvious by hand.
  localparam probe_t PROBES [N_PROBES] = '{
    '{OP_ACK,     32'd0,          32'd10,         1'b1, 16'd2, 1'b1},
    '{OP_TIMEOUT, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 16'd0, 1'b1},
    '{OP_ACK,     32'd100,        32'd110,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd110,        32'd120,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd120,        32'd121,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'hFFFF_FFF0,  32'd5,          1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd0,          32'hFFFF_FFFF,  1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd500,        32'd500,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd510,        32'd560,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd520,        32'd620,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd530,        32'd700,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd540,        32'd800,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd550,        32'd900,        1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd560,        32'd1000,       1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd570,        32'd1100,       1'b0, 16'd0, 1'b0},
    '{OP_TIMEOUT, 32'd0,          32'd0,          1'b1, 16'd0, 1'b1},
    '{OP_ACK,     32'd1200,       32'd1210,       1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd1210,       32'd1300,       1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd1220,       32'd1400,       1'b0, 16'd0, 1'b0},
    '{OP_ACK,     32'd1230,       32'd1500,       1'b0, 16'd0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [31:0] sent_time_ms_i;
  logic [31:0] ack_time_ms_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] window_datagrams_o;
  logic        in_slow_start_o;

  delay_based_congestion_window_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .sent_time_ms_i     (sent_time_ms_i),
    .ack_time_ms_i      (ack_time_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .window_datagrams_o (window_datagrams_o),
    .in_slow_start_o    (in_slow_start_o)
  );

  // Shadow copy of the controller state and registers.
  logic [63:0] cfg_period;
  logic [63:0] cfg_min_win;
  logic [63:0] srtt_q8;
  logic [63:0] lt_min_rtt;
  logic [31:0] lt_min_stamp;
  logic [63:0] st_min_rtt;
  logic [31:0] st_min_stamp;
  logic [63:0] cwnd_q;
  logic [63:0] round_acks;
  logic        slow_start;
  logic [63:0] vel;
  logic [63:0] same_dir;
  logic        last_up;
  logic [63:0] last_win;

  window_res_t pending_windows [$];
  int          fails;
  int          stall_cycles;
  logic        in_burst;
  logic        out_burst;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic close_window_round();
    logic [63:0] floor_win;
    logic [63:0] qd;
    logic [63:0] rhs;
    logic [63:0] step;
    logic        grow;
    logic        up;
    floor_win = (cfg_min_win == 64'd0) ? 64'd1 : cfg_min_win;
    if (cwnd_q == 64'd0) cwnd_q = floor_win << FRAC;
    qd = (st_min_rtt > lt_min_rtt) ? (st_min_rtt - lt_min_rtt) : 64'd0;
    rhs = (st_min_rtt << 1) << FRAC;
    grow = (qd == 64'd0) || (cwnd_q <= rhs / qd);
    step = ((vel << 1) << (2 * FRAC)) / cwnd_q;
    if (grow) begin
      if (slow_start) begin
        cwnd_q = (cwnd_q > (WIN_MAX >> 1)) ? WIN_MAX : (cwnd_q << 1);
      end else begin
        cwnd_q = (step > WIN_MAX - cwnd_q) ? WIN_MAX : (cwnd_q + step);
      end
    end else begin
      slow_start = 1'b0;
      cwnd_q = (step >= cwnd_q) ? 64'd0 : (cwnd_q - step);
    end
    round_acks = 64'd0;
    up = cwnd_q > (last_win << FRAC);
    if (up == last_up) begin
      same_dir = same_dir + 64'd1;
      if (same_dir >= 64'd3) begin
        vel = (vel > 64'd8) ? 64'd2 : (vel << 1);
        same_dir = 64'd0;
      end
    end else begin
      vel = 64'd1;
    end
    last_win = (cwnd_q >> FRAC) & 64'hFFFF;
    last_up = up;
  endtask

  task automatic predict_window(input logic op, input logic [31:0] sent,
                                input logic [31:0] ack, output window_res_t res);
    logic [31:0] diff;
    logic [63:0] rtt;
    logic [63:0] tau;
    if (op == OP_TIMEOUT) begin
      cwnd_q = 64'd0;
      slow_start = 1'b1;
    end else begin
      diff = ack - sent;
      rtt = {32'd0, diff};
      if (srtt_q8 == 64'd0) srtt_q8 = rtt << 8;
      else srtt_q8 = ((64'd7 * srtt_q8 + (rtt << 8)) >> 3) & SRTT_MASK;
      tau = srtt_q8 >> 9;
      diff = ack - lt_min_stamp;
      if ({32'd0, diff} > cfg_period || rtt < lt_min_rtt) begin
        lt_min_rtt = rtt;
        lt_min_stamp = ack;
      end
      diff = ack - st_min_stamp;
      if ({32'd0, diff} > tau || rtt < st_min_rtt) begin
        st_min_rtt = rtt;
        st_min_stamp = ack;
      end
      if (round_acks < 64'hFFFF) round_acks = round_acks + 64'd1;
      if ((round_acks << FRAC) >= cwnd_q) close_window_round();
    end
    res.window = cwnd_q[FRAC +: 16];
    res.slow = slow_start;
  endtask

  // Drives one word and returns at the edge where it is taken; valid stays high.
  task automatic send_word(input logic op, input logic [31:0] sent, input logic [31:0] ack,
                           input logic typed, input window_res_t typed_res);
    int          gap;
    window_res_t res;
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    sent_time_ms_i <= sent;
    ack_time_ms_i <= ack;
    do @(posedge clk_i); while (!in_ready_o);
    predict_window(op, sent, ack, res);
    pending_windows.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    if (idx == dbcw_pkg::CFG_MIN_RTT_PERIOD) cfg_period = {48'd0, data};
    else cfg_min_win = {56'd0, data[7:0]};
    @(posedge clk_i);
  endtask

  // Mostly a plausible flow of acknowledgements whose delay grows with the
  // window, with timeouts, wild timestamps and reordered words mixed in.
  task automatic run_flow(input logic [31:0] start_ms);
    logic [31:0] now_ms;
    logic [31:0] base_ms;
    logic [31:0] rtt_ms;
    logic [31:0] sent;
    logic [31:0] ack;
    int          pick;
    now_ms = start_ms;
    base_ms = $urandom_range(5, 200);
    for (int n = 0; n < WORDS_PER_PHASE; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) == 0) base_ms = $urandom_range(5, 200);
      if (pick < 3) begin
        send_word(OP_TIMEOUT, $urandom, $urandom, 1'b0, '0);
      end else if (pick < 6) begin
        send_word(OP_ACK, $urandom, $urandom, 1'b0, '0);
      end else if (pick < 9) begin
        ack = now_ms - $urandom_range(1, 50);
        sent = ack - $urandom_range(0, 3);
        send_word(OP_ACK, sent, ack, 1'b0, '0);
      end else begin
        now_ms = now_ms + $urandom_range(0, 5);
        rtt_ms = base_ms + 32'(cwnd_q >> (FRAC + 1)) + $urandom_range(0, 3);
        send_word(OP_ACK, now_ms - rtt_ms, now_ms, 1'b0, '0);
      end
    end
  endtask

  task automatic new_settings(input logic [15:0] period, input logic [15:0] min_win);
    drain_results();
    write_reg(dbcw_pkg::CFG_MIN_RTT_PERIOD, period);
    write_reg(dbcw_pkg::CFG_MIN_WINDOW, min_win);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    window_res_t typed_res;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    opcode_i = 1'b0;
    sent_time_ms_i = '0;
    ack_time_ms_i = '0;
    in_burst = 1'b0;
    fails = 0;
    cfg_period = {48'd0, dbcw_pkg::MIN_RTT_PERIOD_RESET};
    cfg_min_win = {56'd0, dbcw_pkg::MIN_WINDOW_RESET};
    srtt_q8 = '0;
    lt_min_rtt = ALL32;
    lt_min_stamp = '0;
    st_min_rtt = ALL32;
    st_min_stamp = '0;
    cwnd_q = 64'd1 << FRAC;
    round_acks = '0;
    slow_start = 1'b1;
    vel = 64'd1;
    same_dir = '0;
    last_up = 1'b1;
    last_win = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_PROBES; i++) begin
      typed_res.window = PROBES[i].window;
      typed_res.slow = PROBES[i].slow;
      send_word(PROBES[i].op, PROBES[i].sent, PROBES[i].ack, PROBES[i].typed, typed_res);
    end
    run_flow($urandom);

    new_settings(16'd1, 16'd1);
    run_flow($urandom);
    new_settings(16'hFFFF, 16'h00FF);
    run_flow($urandom);
    // The low byte of the window word is zero here, so the floor becomes one;
    // the flow also starts just short of the millisecond counter wrapping.
    new_settings(16'd50, 16'hFF00);
    run_flow(32'hFFFF_F000);
    new_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 255)));
    run_flow($urandom);
    new_settings(16'd300, 16'd4);
    run_flow($urandom);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_delay_based_congestion_window_core passed");
    end else begin
      $display("tb_delay_based_congestion_window_core failed");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    out_burst = 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_results
    window_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected result word window %0d slow start %0b",
                 $time, window_datagrams_o, in_slow_start_o);
        fails++;
      end else begin
        want = pending_windows.pop_front();
        if (window_datagrams_o !== want.window) begin
          $display("%0t: window expected %0d actual %0d",
                   $time, want.window, window_datagrams_o);
          fails++;
        end
        if (in_slow_start_o !== want.slow) begin
          $display("%0t: slow start expected %0b actual %0b",
                   $time, want.slow, in_slow_start_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_delay_based_congestion_window_core failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/dbcw_pkg.sv
rtl/delay_based_congestion_window_core.sv
tb/tb_delay_based_congestion_window_core.sv
